### design/ole_pkg.sv
package ole_pkg;

    typedef enum logic [2:0] {
        OP_ADD_FRONT    = 3'd0,
        OP_ADD_END      = 3'd1,
        OP_ADD_AT       = 3'd2,
        OP_REMOVE_FRONT = 3'd3,
        OP_REMOVE_END   = 3'd4,
        OP_REMOVE_AT    = 3'd5,
        OP_SEARCH       = 3'd6,
        OP_CLEAR        = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] data_value;
        logic [5:0]         position;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic               found;
        logic [6:0]         entry_total;
        logic               is_empty;
        logic signed [31:0] head_value;
        logic signed [31:0] tail_value;
    } out_word_t;

    // Datapath commands issued by the controller each cycle.
    typedef struct packed {
        logic load_item;   // capture input word and clear flags
        logic set_walk;    // load walk index from walk_start
        logic rd_issue;    // read memory at walk index
        logic rd_next;     // read memory at walk index + 1
        logic wr_shift;    // write last read data to walk index
        logic wr_item;     // write item value at walk index
        logic step_up;     // walk index + 1
        logic step_down;   // walk index - 1
        logic cap_removed; // capture read data as removed value
        logic cmp_search;  // compare read data with key
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clear;
        logic rd_head;     // read entry 0
        logic rd_tail;     // read entry count-1
        logic cap_head;
        logic cap_tail;
        logic set_status;
        logic [1:0] status;
        logic wr_dir_up;   // read goes to index-1 (insert)
        logic [1:0] start_sel; // 0 count,1 zero,2 position,3 count-1
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       full;
        logic       empty;
        logic       add_bad;
        logic       rem_bad;
        logic       walk_gt_target; // insert: index > target
        logic       walk_last;      // remove/search: index+1 >= count
        logic       hit;
    } dp_stat_t;

endpackage

### design/ole_ram.sv
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/ole_datapath.sv
module ole_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ole_pkg::in_word_t in_word,
    input  ole_pkg::dp_cmd_t  cmd,
    output ole_pkg::dp_stat_t stat,
    output ole_pkg::out_word_t result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      walk_reg;
    logic [CW-1:0]      target_reg;
    logic [2:0]         op_reg;
    logic signed [31:0] value_reg;
    logic [5:0]         pos_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] removed_reg;
    logic               found_reg;
    logic signed [31:0] head_reg;
    logic signed [31:0] tail_reg;

    logic [31:0]    rd_data;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [31:0]    wr_data;
    logic           wr_en;
    logic [CW-1:0]  pos_ext;
    logic [PW-1:0]  pos_wide;
    logic [PW-1:0]  count_wide;
    logic [CW-1:0]  walk_start;
    logic [CW-1:0]  walk_plus;
    logic [CW-1:0]  walk_minus;

    assign pos_ext    = CW'(pos_reg);
    assign pos_wide   = PW'(pos_reg);
    assign count_wide = PW'(count_reg);
    assign walk_plus  = walk_reg + CW'(1);
    assign walk_minus = walk_reg - CW'(1);

    always_comb
    begin
        unique case (cmd.start_sel)
            2'd0:    walk_start = count_reg;
            2'd1:    walk_start = '0;
            2'd3:    walk_start = count_reg - CW'(1);
            default: walk_start = pos_ext;
        endcase
    end

    always_comb
    begin
        priority if (cmd.rd_head)
        begin
            rd_addr = '0;
        end
        else if (cmd.rd_tail)
        begin
            rd_addr = AW'(count_reg - CW'(1));
        end
        else if (cmd.rd_next)
        begin
            rd_addr = AW'(walk_plus);
        end
        else if (cmd.rd_issue && cmd.wr_dir_up)
        begin
            rd_addr = AW'(walk_minus);
        end
        else
        begin
            rd_addr = AW'(walk_reg);
        end
    end

    // Insert walks down: read index-1, write it at index. Remove walks up:
    // read index+1, write it at index. Each moved entry is read and then
    // written back.
    assign wr_en   = cmd.wr_shift || cmd.wr_item;
    assign wr_addr = AW'(walk_reg);
    assign wr_data = cmd.wr_item ? 32'(value_reg) : rd_data;

    ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            priority if (cmd.cnt_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg      <= in_word.operation;
            value_reg   <= in_word.data_value;
            pos_reg     <= in_word.position;
            status_reg  <= ole_pkg::ST_OK;
            removed_reg <= '0;
            found_reg   <= 1'b0;
        end
        if (cmd.set_walk)
        begin
            walk_reg   <= walk_start;
            target_reg <= (op_reg == ole_pkg::OP_ADD_FRONT) ? '0 :
                          (op_reg == ole_pkg::OP_ADD_END) ? count_reg : pos_ext;
        end
        else if (cmd.step_up)
        begin
            walk_reg <= walk_plus;
        end
        else if (cmd.step_down)
        begin
            walk_reg <= walk_minus;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.cap_removed)
        begin
            removed_reg <= rd_data;
        end
        if (cmd.cmp_search && (rd_data == 32'(value_reg)))
        begin
            found_reg <= 1'b1;
        end
        if (cmd.cap_head)
        begin
            head_reg <= (count_reg == '0) ? '0 : rd_data;
        end
        if (cmd.cap_tail)
        begin
            tail_reg <= (count_reg == '0) ? '0 : rd_data;
        end
    end

    assign stat.operation      = op_reg;
    assign stat.full           = (count_reg >= CW'(CAPACITY));
    assign stat.empty          = (count_reg == '0);
    assign stat.add_bad        = (pos_wide > count_wide);
    assign stat.rem_bad        = (pos_wide >= count_wide);
    assign stat.walk_gt_target = (walk_reg > target_reg);
    assign stat.walk_last      = (walk_plus >= count_reg);
    assign stat.hit            = (rd_data == 32'(value_reg));

    assign result.status        = status_reg;
    assign result.removed_value = removed_reg;
    assign result.found         = found_reg;
    assign result.entry_total   = 7'(count_reg);
    assign result.is_empty      = (count_reg == '0);
    assign result.head_value    = head_reg;
    assign result.tail_value    = tail_reg;

endmodule

### design/ole_control.sv
module ole_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  ole_pkg::dp_stat_t stat,
    output ole_pkg::dp_cmd_t  cmd,
    output logic              in_ready,
    output logic              out_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_CAP,
        S_REM_SH,
        S_REM_CHK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_HEAD,
        S_TAIL,
        S_TAIL_CAP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_walk = 1'b1;
                unique case (stat.operation)
                    ole_pkg::OP_ADD_FRONT, ole_pkg::OP_ADD_END, ole_pkg::OP_ADD_AT:
                    begin
                        cmd.start_sel = 2'd0;
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::ST_FULL;
                            state_next     = S_HEAD;
                        end
                        else if (stat.operation == ole_pkg::OP_ADD_AT && stat.add_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::ST_BADPOS;
                            state_next     = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    ole_pkg::OP_REMOVE_FRONT, ole_pkg::OP_REMOVE_END, ole_pkg::OP_REMOVE_AT:
                    begin
                        cmd.start_sel = (stat.operation == ole_pkg::OP_REMOVE_FRONT) ? 2'd1 :
                                        (stat.operation == ole_pkg::OP_REMOVE_AT) ? 2'd2 :
                                        2'd3;
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::ST_EMPTY;
                            state_next     = S_HEAD;
                        end
                        else if (stat.operation == ole_pkg::OP_REMOVE_AT && stat.rem_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ole_pkg::ST_BADPOS;
                            state_next     = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_REM_RD;
                        end
                    end
                    ole_pkg::OP_SEARCH:
                    begin
                        cmd.start_sel = 2'd1;
                        state_next    = stat.empty ? S_HEAD : S_SRCH_RD;
                    end
                    default:
                    begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = S_HEAD;
                    end
                endcase
            end
            S_INS_RD:
            begin
                // Walk index starts at count and moves down to the target.
                if (stat.walk_gt_target)
                begin
                    cmd.rd_issue  = 1'b1;
                    cmd.wr_dir_up = 1'b1;
                    state_next    = S_INS_WR;
                end
                else
                begin
                    cmd.wr_item = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_HEAD;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_shift  = 1'b1;
                cmd.step_down = 1'b1;
                state_next    = S_INS_RD;
            end
            S_REM_RD:
            begin
                // The walk index starts at the entry being removed.
                cmd.rd_issue = 1'b1;
                state_next   = S_REM_CAP;
            end
            S_REM_CAP:
            begin
                cmd.cap_removed = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_HEAD;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_REM_SH;
                end
            end
            S_REM_SH:
            begin
                // Read data holds entry walk+1; store it at walk.
                cmd.wr_shift = 1'b1;
                cmd.step_up  = 1'b1;
                state_next   = S_REM_CHK;
            end
            S_REM_CHK:
            begin
                if (stat.walk_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_HEAD;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_REM_SH;
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                cmd.cmp_search = 1'b1;
                if (stat.hit || stat.walk_last)
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    cmd.step_up = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_HEAD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_TAIL;
            end
            S_TAIL:
            begin
                cmd.cap_head = 1'b1;
                cmd.rd_tail  = 1'b1;
                state_next   = S_TAIL_CAP;
            end
            S_TAIL_CAP:
            begin
                cmd.cap_tail = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= (state_next == S_OUT);
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    property p_out_only_in_out_state;
        @(posedge clk) disable iff (!rst_n) out_valid |-> (state_reg == S_OUT);
    endproperty
    a_out_state: assert property (p_out_only_in_out_state)
        else $error("result valid outside output state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_fire |=> out_valid)
        else $error("result dropped before taken");

endmodule

### design/ordered_list_engine.sv
// Ordered list engine: keeps up to CAPACITY signed 32-bit values in order.
// Input channel (in_valid/in_ready/in_data) takes one word per operation:
// add at front, end or position, remove at front, end or position, search,
// or clear. Output channel (out_valid/out_ready/out_data) returns exactly one
// result word per input word, with status, removed value, found flag, count,
// empty flag and head and tail values after the operation.
// One word is processed at a time. The values live in a single-port-write,
// registered-read RAM, and shifting or searching walks it one entry at a
// time. The next input word can be taken from the cycle after the result
// word is taken.
// Reset clears the count and the controller; RAM contents are not cleared,
// since only entries below the count are used. While out_valid is high and
// out_ready is low the result holds and in_ready stays low.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ole_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ole_pkg::out_word_t   out_data
);

    ole_pkg::dp_cmd_t  cmd;
    ole_pkg::dp_stat_t stat;
    logic              in_fire;
    logic              out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    ole_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    ole_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

endmodule

### dv/tb_ordered_list_engine.sv
`timescale 1ns / 100ps

module tb_ordered_list_engine;

    localparam int CAP = 64;
    localparam int CYCLE_LIMIT = 1500000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ole_pkg::in_word_t  in_data;
    logic               out_valid;
    logic               out_ready;
    ole_pkg::out_word_t out_data;

    ordered_list_engine #(.CAPACITY(CAP)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Shadow copy of the list contents.
    logic signed [31:0] shadow_list [CAP];
    int unsigned        shadow_count;
    ole_pkg::out_word_t pending_results [$];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    longint             cycle_count;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_ordered_list_engine NOT OK");
            $finish;
        end
    end

    function automatic ole_pkg::out_word_t apply_list_op(ole_pkg::in_word_t w);
        ole_pkg::out_word_t r;
        ole_pkg::op_t op;
        int unsigned p;
        op = ole_pkg::op_t'(w.operation);
        p = w.position;
        r = '0;
        r.status = ole_pkg::ST_OK;
        case (op)
            ole_pkg::OP_ADD_FRONT, ole_pkg::OP_ADD_END, ole_pkg::OP_ADD_AT:
            begin
                if (shadow_count >= CAP)
                    r.status = ole_pkg::ST_FULL;
                else if (op == ole_pkg::OP_ADD_AT && p > shadow_count)
                    r.status = ole_pkg::ST_BADPOS;
                else
                begin
                    if (op == ole_pkg::OP_ADD_FRONT)
                        p = 0;
                    else if (op == ole_pkg::OP_ADD_END)
                        p = shadow_count;
                    for (int i = shadow_count; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = w.data_value;
                    shadow_count++;
                end
            end
            ole_pkg::OP_REMOVE_FRONT, ole_pkg::OP_REMOVE_END, ole_pkg::OP_REMOVE_AT:
            begin
                if (shadow_count == 0)
                    r.status = ole_pkg::ST_EMPTY;
                else if (op == ole_pkg::OP_REMOVE_AT && p >= shadow_count)
                    r.status = ole_pkg::ST_BADPOS;
                else
                begin
                    if (op == ole_pkg::OP_REMOVE_FRONT)
                        p = 0;
                    else if (op == ole_pkg::OP_REMOVE_END)
                        p = shadow_count - 1;
                    r.removed_value = shadow_list[p];
                    for (int i = p; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            ole_pkg::OP_SEARCH:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_list[i] == w.data_value)
                        r.found = 1'b1;
            end
            default:
                shadow_count = 0;
        endcase
        r.entry_total = shadow_count[6:0];
        r.is_empty = (shadow_count == 0);
        if (shadow_count != 0)
        begin
            r.head_value = shadow_list[0];
            r.tail_value = shadow_list[shadow_count-1];
        end
        return r;
    endfunction

    // Valid stays high between back-to-back words; it drops only while idle.
    task automatic send_word(ole_pkg::op_t op, logic signed [31:0] value,
                             int unsigned pos);
        ole_pkg::in_word_t w;
        w.operation = op;
        w.data_value = value;
        w.position = pos[5:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_list_op(w));
        @(negedge clk);
    endtask

    // Receiver: stalls at random, checks each accepted result word.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", out_data);
            end
            else
            begin
                ole_pkg::out_word_t e;
                e = pending_results.pop_front();
                if (out_data !== e)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h got %h", e, out_data);
                end
            end
        end
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(ole_pkg::OP_REMOVE_FRONT, 0, 0);
        send_word(ole_pkg::OP_REMOVE_END, 0, 0);
        send_word(ole_pkg::OP_REMOVE_AT, 0, 0);
        send_word(ole_pkg::OP_SEARCH, 5, 0);
        send_word(ole_pkg::OP_ADD_AT, 1, 1);
        send_word(ole_pkg::OP_ADD_FRONT, 32'sh7fffffff, 0);
        send_word(ole_pkg::OP_ADD_END, 32'sh80000000, 63);
        send_word(ole_pkg::OP_ADD_AT, -1, 1);
        send_word(ole_pkg::OP_ADD_AT, 32'h55555555, 3);
        send_word(ole_pkg::OP_ADD_AT, 32'h2aaaaaaa, 5);
        send_word(ole_pkg::OP_SEARCH, 32'sh80000000, 0);
        send_word(ole_pkg::OP_SEARCH, 12345, 0);
        send_word(ole_pkg::OP_REMOVE_AT, 0, 4);
        send_word(ole_pkg::OP_REMOVE_AT, 0, 63);
        send_word(ole_pkg::OP_REMOVE_AT, 0, 1);
        send_word(ole_pkg::OP_REMOVE_END, 0, 0);
        send_word(ole_pkg::OP_REMOVE_FRONT, 0, 0);
        send_word(ole_pkg::OP_CLEAR, 0, 0);
        send_word(ole_pkg::OP_CLEAR, 0, 0);
        drain_results();
    endtask

    // Fill to capacity, then exercise the full cases and the deepest walks.
    task automatic test_full_list();
        for (int i = 0; i < CAP; i++)
            send_word(ole_pkg::OP_ADD_END, $urandom, 0);
        send_word(ole_pkg::OP_ADD_FRONT, 1, 0);
        send_word(ole_pkg::OP_ADD_END, 1, 0);
        send_word(ole_pkg::OP_ADD_AT, 1, 63);
        send_word(ole_pkg::OP_ADD_AT, 1, 0);
        send_word(ole_pkg::OP_SEARCH, shadow_list[CAP-1], 0);
        send_word(ole_pkg::OP_REMOVE_AT, 0, 63);
        send_word(ole_pkg::OP_ADD_AT, -7, 63);
        send_word(ole_pkg::OP_REMOVE_FRONT, 0, 0);
        send_word(ole_pkg::OP_ADD_AT, 9, 0);
        send_word(ole_pkg::OP_CLEAR, 0, 0);
        drain_results();
    endtask

    task automatic test_random(int n);
        ole_pkg::op_t op;
        int unsigned pos;
        logic signed [31:0] v;
        for (int k = 0; k < n; k++)
        begin
            op = ole_pkg::op_t'($urandom_range(7));
            // Keep clears rare and lean toward inserts so the list grows deep.
            if (op == ole_pkg::OP_CLEAR && $urandom_range(9) != 0)
                op = ole_pkg::op_t'($urandom_range(2));
            else if (shadow_count < 20 && $urandom_range(1))
                op = ole_pkg::op_t'($urandom_range(2));
            if ($urandom_range(3) == 0)
                pos = $urandom_range(63);
            else
                pos = $urandom_range(shadow_count);
            v = pick_value();
            if (op == ole_pkg::OP_SEARCH && shadow_count != 0 && $urandom_range(1))
                v = shadow_list[$urandom_range(shadow_count-1)];
            send_word(op, v, pos);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        shadow_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_list();
        test_random(120);
        send_idle_pct = 47;
        test_random(120);
        send_idle_pct = 0;
        recv_stall_pct = 47;
        test_random(120);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        test_random(120);
        drain_results();
        if (mismatch_count == 0)
            $display("tb_ordered_list_engine OK");
        else
            $display("tb_ordered_list_engine NOT OK");
        $finish;
    end

endmodule
